// ===== rtl/tmtpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtpc_pkg
// shared widths, constants and types of the trimmed-mean calibrator
// ----------------------------------------------------------------------------
package tmtpc_pkg;
	localparam int WINDOW_LEN = 10;
	localparam int TRIM_LOW   = 3;
	localparam int TRIM_COUNT = 4;
	localparam int NUM_CH     = 8;
	localparam int NUM_MEAS   = 6;
	localparam int CODE_W     = 16;
	localparam int REG_W      = 22;
	localparam int OUT_W      = 24;
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
	localparam int RANK_W     = $clog2(WINDOW_LEN);
	localparam int SUM_W      = CODE_W + 2;
	// numerator: |s*(r1-r0)| + |s_lo*r1| + |r0*s_hi| < 2^42
	localparam int NUM_W      = SUM_W + REG_W + 3;
	localparam int DEN_W      = SUM_W + 1;
	localparam int QUO_W      = NUM_W;
	localparam int IDX_W      = 1;

	localparam logic [IDX_W-1:0] REG_REF_LOW  = 1'b0;
	localparam logic [IDX_W-1:0] REG_REF_HIGH = 1'b1;

	localparam logic [REG_W-1:0] REF_LOW_RST  = REG_W'(420000);
	localparam logic [REG_W-1:0] REF_HIGH_RST = REG_W'(1653000);

	localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// control from the sequencer to the cell row
	typedef struct packed {
		logic shift;   // shift in a new word
		logic sort;    // one compare-exchange pass
		logic phase;   // odd/even pass
	} row_ctl_t;
endpackage

// ===== rtl/tmtpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtpc_in_if / tmtpc_out_if
// valid/ready channels of the calibrator
// ----------------------------------------------------------------------------
interface tmtpc_in_if;
	logic valid;
	logic ready;
	logic [15:0] code_ref_low;
	logic [15:0] code_a1;
	logic [15:0] code_a2;
	logic [15:0] code_a3;
	logic [15:0] code_ref_high;
	logic [15:0] code_b1;
	logic [15:0] code_b2;
	logic [15:0] code_b3;
	modport source (output valid, code_ref_low, code_a1, code_a2, code_a3,
		code_ref_high, code_b1, code_b2, code_b3, input ready);
	modport sink (input valid, code_ref_low, code_a1, code_a2, code_a3,
		code_ref_high, code_b1, code_b2, code_b3, output ready);
endinterface

interface tmtpc_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] volts_a1;
	logic signed [23:0] volts_a2;
	logic signed [23:0] volts_a3;
	logic signed [23:0] volts_b1;
	logic signed [23:0] volts_b2;
	logic signed [23:0] volts_b3;
	logic cal_error;
	modport source (output valid, volts_a1, volts_a2, volts_a3, volts_b1, volts_b2,
		volts_b3, cal_error, input ready);
	modport sink (input valid, volts_a1, volts_a2, volts_a3, volts_b1, volts_b2,
		volts_b3, cal_error, output ready);
endinterface

// ===== rtl/trimmed_mean_two_point_calibrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_two_point_calibrator_unit
// median-average filter of eight channels and two-point calibration
// ----------------------------------------------------------------------------
// Each input word is one eight-channel conversion set; it shifts into a
// chain of ten cells per channel. Every tenth word closes a window: the
// chains sort in ten odd-even passes, ranks three to six are summed, and six
// channels are calibrated one after another, each through the product
// pipeline and a divide of 43 quotient bits at one per cycle before its
// result is stored. When the reference sums are equal, the result word is
// offered without any divide. No word is taken while a window is processed.
// While a result word waits, the next window's first nine words are taken
// and the tenth waits until the result word is taken.
module trimmed_mean_two_point_calibrator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [21:0]     cfg_data,
	tmtpc_in_if.sink        in_ch,
	tmtpc_out_if.source     out_ch
);
	localparam int N = tmtpc_pkg::WINDOW_LEN;
	localparam int NW = tmtpc_pkg::NUM_W;
	localparam int PW = tmtpc_pkg::REG_W + tmtpc_pkg::SUM_W;

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_SORT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;

	logic [2:0] state_q;
	logic [tmtpc_pkg::CNT_W-1:0] cnt_q;
	logic [tmtpc_pkg::RANK_W-1:0] pass_q;
	logic [2:0] ch_q;
	logic [21:0] r0_q, r1_q;
	tmtpc_pkg::row_ctl_t ctl;
	tmtpc_pkg::code_t din [tmtpc_pkg::NUM_CH];
	tmtpc_pkg::sum_t  sums [tmtpc_pkg::NUM_CH];
	logic accept;
	logic oval_q;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_FILL) &&
		!(oval_q && cnt_q == tmtpc_pkg::CNT_W'(N - 1));

	assign din[0] = in_ch.code_ref_low;
	assign din[1] = in_ch.code_a1;
	assign din[2] = in_ch.code_a2;
	assign din[3] = in_ch.code_a3;
	assign din[4] = in_ch.code_ref_high;
	assign din[5] = in_ch.code_b1;
	assign din[6] = in_ch.code_b2;
	assign din[7] = in_ch.code_b3;

	assign ctl.shift = accept;
	assign ctl.sort  = (state_q == ST_SORT);
	assign ctl.phase = pass_q[0];

	for (genvar c = 0; c < tmtpc_pkg::NUM_CH; c++) begin : g_row
		tmtpc_row u_row (.clk(clk), .ctl(ctl), .din(din[c]), .trim_sum(sums[c]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= tmtpc_pkg::REF_LOW_RST;
			r1_q <= tmtpc_pkg::REF_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmtpc_pkg::REG_REF_LOW:  r0_q <= cfg_data;
				tmtpc_pkg::REG_REF_HIGH: r1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// measurement channel select
	tmtpc_pkg::sum_t s_sel;
	always_comb begin
		case (ch_q)
			3'd0: s_sel = sums[1];
			3'd1: s_sel = sums[2];
			3'd2: s_sel = sums[3];
			3'd3: s_sel = sums[5];
			3'd4: s_sel = sums[6];
			3'd5: s_sel = sums[7];
			default: s_sel = '0;
		endcase
	end

	// numerator n = s*(r1-r0) + (r0*s_hi - s_lo*r1), products registered
	logic [PW-1:0] a_p, b_p;
	logic signed [tmtpc_pkg::REG_W:0] dr;
	logic signed [PW:0] p_p;
	logic signed [NW-1:0] p_s1, k_s1, a_s1, b_s1;
	logic signed [NW-1:0] num_s;
	logic signed [tmtpc_pkg::DEN_W-1:0] den_s;
	logic neg_s;
	logic [NW-1:0] num_abs;
	logic [tmtpc_pkg::DEN_W-1:0] den_abs;
	logic div_start, div_done;
	logic [NW-1:0] quo;
	logic [1:0] mstep_q;

	assign den_s = $signed({1'b0, sums[4]}) - $signed({1'b0, sums[0]});
	assign num_s = p_s1 + k_s1;

	assign a_p = r0_q * sums[4];
	assign b_p = r1_q * sums[0];
	assign dr  = $signed({1'b0, r1_q}) - $signed({1'b0, r0_q});
	assign p_p = $signed({1'b0, s_sel}) * dr;

	always_ff @(posedge clk) begin
		a_s1 <= NW'(a_p);
		b_s1 <= NW'(b_p);
		k_s1 <= a_s1 - b_s1;
		p_s1 <= NW'(p_p);
	end

	always_comb begin
		logic signed [NW-1:0] n2;
		logic signed [tmtpc_pkg::DEN_W-1:0] d2;
		n2 = den_s[tmtpc_pkg::DEN_W-1] ? -num_s : num_s;
		d2 = den_s[tmtpc_pkg::DEN_W-1] ? -den_s : den_s;
		neg_s   = n2[NW-1];
		den_abs = d2;
		num_abs = NW'(n2[NW-1] ? -n2 : n2) + NW'(d2 >> 1);
	end

	logic neg_q;
	assign div_start = (state_q == ST_MUL) && (mstep_q == 2'd3);

	tmtpc_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_abs),
		.den(den_abs), .done(div_done), .quo(quo));

	logic signed [tmtpc_pkg::OUT_W-1:0] sat;
	always_comb begin
		if (quo > NW'(tmtpc_pkg::SAT_HI) + NW'(neg_q)) begin
			sat = neg_q ? tmtpc_pkg::SAT_LO : tmtpc_pkg::SAT_HI;
		end else if (neg_q) begin
			sat = tmtpc_pkg::OUT_W'(-quo);
		end else begin
			sat = tmtpc_pkg::OUT_W'(quo);
		end
	end

	logic signed [tmtpc_pkg::OUT_W-1:0] res_q [tmtpc_pkg::NUM_MEAS];
	logic err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			cnt_q   <= '0;
			pass_q  <= '0;
			ch_q    <= '0;
			mstep_q <= '0;
			err_q   <= 1'b0;
			neg_q   <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (cnt_q == tmtpc_pkg::CNT_W'(N - 1)) begin
							cnt_q   <= '0;
							pass_q  <= '0;
							state_q <= ST_SORT;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == tmtpc_pkg::RANK_W'(N - 1)) begin
						ch_q    <= '0;
						mstep_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd3) begin
						err_q <= (den_s == '0);
						neg_q <= neg_s;
						if (den_s == '0) begin
							oval_q  <= 1'b1;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q[ch_q] <= sat;
						if (ch_q == 3'(tmtpc_pkg::NUM_MEAS - 1)) begin
							oval_q  <= 1'b1;
							state_q <= ST_FILL;
						end else begin
							ch_q    <= ch_q + 1'b1;
							mstep_q <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	assign out_ch.valid     = oval_q;
	assign out_ch.cal_error = err_q;
	assign out_ch.volts_a1  = err_q ? '0 : res_q[0];
	assign out_ch.volts_a2  = err_q ? '0 : res_q[1];
	assign out_ch.volts_a3  = err_q ? '0 : res_q[2];
	assign out_ch.volts_b1  = err_q ? '0 : res_q[3];
	assign out_ch.volts_b2  = err_q ? '0 : res_q[4];
	assign out_ch.volts_b3  = err_q ? '0 : res_q[5];

	a_no_in_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FILL) |-> !in_ch.ready)
		else $error("input taken while busy");
	a_sort_after_tenth: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cnt_q == tmtpc_pkg::CNT_W'(N - 1)) |=> (state_q == ST_SORT))
		else $error("window did not close");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.cal_error) |-> (out_ch.volts_a1 == '0))
		else $error("error result not zero");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=>
		(out_ch.valid && $stable(out_ch.volts_a1) && $stable(out_ch.cal_error)))
		else $error("waiting word changed");
endmodule

// ===== rtl/tmtpc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtpc_cell
// one window slot: holds a code, shifts or compare-exchanges with neighbor
// ----------------------------------------------------------------------------
module tmtpc_cell (
	input  logic                 clk,
	input  logic                 shift,
	input  logic                 swap_lo,  // take the lower of self and right
	input  logic                 swap_hi,  // take the higher of self and left
	input  tmtpc_pkg::code_t     left,
	input  tmtpc_pkg::code_t     right,
	output tmtpc_pkg::code_t     value
);
	tmtpc_pkg::code_t value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= left;
		end else if (swap_lo && right < value_q) begin
			value_q <= right;
		end else if (swap_hi && left > value_q) begin
			value_q <= left;
		end
	end

	assign value = value_q;
endmodule

// ===== rtl/tmtpc_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtpc_row
// chain of cells for one channel: shift register and odd-even sorter
// ----------------------------------------------------------------------------
module tmtpc_row (
	input  logic                clk,
	input  tmtpc_pkg::row_ctl_t ctl,
	input  tmtpc_pkg::code_t    din,
	output tmtpc_pkg::sum_t     trim_sum
);
	localparam int N = tmtpc_pkg::WINDOW_LEN;

	tmtpc_pkg::code_t v [N];
	tmtpc_pkg::sum_t  acc;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic lo_en, hi_en;
		tmtpc_pkg::code_t lft, rgt;
		// pair (i, i+1) active when i parity matches phase
		assign lo_en = ctl.sort && (i + 1 < N) && ((i % 2) == int'(ctl.phase));
		assign hi_en = ctl.sort && (i > 0) && (((i - 1) % 2) == int'(ctl.phase));
		assign lft   = (i == 0) ? din : v[(i == 0) ? 0 : i - 1];
		assign rgt   = (i + 1 < N) ? v[(i + 1 < N) ? i + 1 : i] : v[i];
		tmtpc_cell u_cell (
			.clk     (clk),
			.shift   (ctl.shift),
			.swap_lo (lo_en),
			.swap_hi (hi_en),
			.left    (lft),
			.right   (rgt),
			.value   (v[i])
		);
	end

	always_comb begin
		acc = '0;
		for (int k = tmtpc_pkg::TRIM_LOW; k < tmtpc_pkg::TRIM_LOW + tmtpc_pkg::TRIM_COUNT; k++) begin
			if (k < N) begin
				acc = acc + tmtpc_pkg::SUM_W'(v[k]);
			end
		end
	end

	assign trim_sum = acc;
endmodule

// ===== rtl/tmtpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtpc_div
// restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
module tmtpc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tmtpc_pkg::NUM_W-1:0]       num,
	input  logic [tmtpc_pkg::DEN_W-1:0]       den,
	output logic                              done,
	output logic [tmtpc_pkg::QUO_W-1:0]       quo
);
	localparam int N = tmtpc_pkg::NUM_W;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]       q_q;
	logic [tmtpc_pkg::DEN_W:0] r_q;
	logic [tmtpc_pkg::DEN_W-1:0] d_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic [tmtpc_pkg::DEN_W:0] r_sh;

	assign r_sh = {r_q[tmtpc_pkg::DEN_W-1:0], q_q[N-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
